/* sv/fss_pkg.sv */
// ----------------------------------------------------------------------------
// fss_pkg: shared definitions for the first substring match block
// Sizes, command codes, the case folding function and the cell control type.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 4096;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int TI_W  = $clog2(TEXT_MAX);
  localparam int CMP_W = (LEN_W > TI_W) ? LEN_W : TI_W;
  localparam int POS_W = 13;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  typedef struct packed {
    logic       step;
    logic       clear;
    logic       fold_case;
    logic [7:0] ch_raw;
    logic [7:0] text_f;
  } fss_cell_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic en, input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (en && (c inside {[8'h41:8'h5A]})) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

/* sv/fss_if.sv */
// ----------------------------------------------------------------------------
// fss_if: item channels of the first substring match block
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface fss_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] ch;
  logic       last;
  logic       empty_req;

  modport source (output valid, output cmd, output ch, output last, output empty_req,
                  input ready);
  modport sink   (input valid, input cmd, input ch, input last, input empty_req,
                  output ready);
endinterface

interface fss_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fss_pkg::POS_W-1:0] position;
  logic                             found;

  modport source (output valid, output position, output found, input ready);
  modport sink   (input valid, input position, input found, output ready);
endinterface

interface fss_cfg_if;
  logic valid;
  logic ready;
  logic fold_case;

  modport source (output valid, output fold_case, input ready);
  modport sink   (input valid, input fold_case, output ready);
endinterface

/* sv/fss_cell.sv */
// ----------------------------------------------------------------------------
// fss_cell: one pattern position of the match chain
// Holds one pattern byte and one partial match bit, fed by its left neighbor.
// ----------------------------------------------------------------------------
module fss_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fss_pkg::fss_cell_ctrl_t ctrl,
  input  logic                    load,
  input  logic                    active,
  input  logic                    prev_bit,
  output logic                    bit_q,
  output logic                    bit_nxt
);

  logic [7:0] pat_r;
  logic       bit_r;
  logic       eq;

  assign eq      = (fss_pkg::fold_byte(ctrl.fold_case, pat_r) == ctrl.text_f);
  assign bit_nxt = prev_bit & active & eq;
  assign bit_q   = bit_r;

  always_ff @(posedge clk) begin
    if (load) begin
      pat_r <= ctrl.ch_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else if (ctrl.clear) begin
      bit_r <= 1'b0;
    end else if (ctrl.step) begin
      bit_r <= bit_nxt;
    end
  end

endmodule

/* sv/first_substring_match.sv */
// ----------------------------------------------------------------------------
// first_substring_match: streaming first occurrence substring search
// A result appears in the output register in the cycle after its last
// text item is accepted. Throughput: one item per cycle, set by the cell
// chain update, unless an unread result stalls input. Reset is synchronous
// and clears job state; fold_case resets to 1. Pattern bytes have no reset.
// ----------------------------------------------------------------------------
module first_substring_match (
  input  logic      clk,
  input  logic      rst_n,
  fss_in_if.sink    in_if,
  fss_out_if.source out_if,
  fss_cfg_if.sink   cfg_if
);

  localparam int PM = fss_pkg::PATTERN_MAX;

  logic                        fold_case_r;
  logic [fss_pkg::LEN_W-1:0]   len_r;
  logic [fss_pkg::TI_W-1:0]    ti_r;
  logic                        found_r;
  logic [fss_pkg::TI_W-1:0]    start_r;
  logic                        out_valid_r;
  logic [fss_pkg::POS_W-1:0]   out_pos_r;
  logic                        out_found_r;

  logic                        acc;
  logic                        pat_load;
  logic                        step;
  logic                        emit;
  logic                        hit;
  logic [fss_pkg::LEN_W-1:0]   top;
  logic [fss_pkg::CMP_W-1:0]   ti_ext;
  logic [fss_pkg::CMP_W-1:0]   top_ext;
  logic [fss_pkg::TI_W-1:0]    start_now;
  logic                        found_cur;
  logic [fss_pkg::TI_W-1:0]    start_cur;
  logic [fss_pkg::POS_W-1:0]   pos_nxt;
  logic [PM-1:0]               bits_q;
  logic [PM-1:0]               bits_nxt;
  logic [PM-1:0]               is_top;
  fss_pkg::fss_cell_ctrl_t     ctrl;

  assign in_if.ready     = !out_valid_r || out_if.ready;
  assign cfg_if.ready    = 1'b1;
  assign out_if.valid    = out_valid_r;
  assign out_if.position = out_pos_r;
  assign out_if.found    = out_found_r;

  assign acc      = in_if.valid && in_if.ready;
  assign pat_load = acc && (in_if.cmd == fss_pkg::CMD_PATTERN) && !in_if.empty_req
                    && (len_r < fss_pkg::LEN_W'(PM));
  assign step     = acc && (in_if.cmd == fss_pkg::CMD_TEXT) && !in_if.empty_req;
  assign emit     = acc && (in_if.cmd == fss_pkg::CMD_TEXT) && in_if.last;

  assign ctrl.step      = step;
  assign ctrl.clear     = emit;
  assign ctrl.fold_case = fold_case_r;
  assign ctrl.ch_raw    = in_if.ch;
  assign ctrl.text_f    = fss_pkg::fold_byte(fold_case_r, in_if.ch);

  for (genvar j = 0; j < PM; j++) begin : g_cell
    logic prev;
    if (j == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = bits_q[j-1];
    end
    assign is_top[j] = (len_r == fss_pkg::LEN_W'(j + 1));
    fss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .load     (pat_load && (len_r == fss_pkg::LEN_W'(j))),
      .active   (len_r > fss_pkg::LEN_W'(j)),
      .prev_bit (prev),
      .bit_q    (bits_q[j]),
      .bit_nxt  (bits_nxt[j])
    );
  end

  assign hit       = step && !found_r && (|(bits_nxt & is_top));
  assign top       = len_r - fss_pkg::LEN_W'(1);
  assign ti_ext    = fss_pkg::CMP_W'(ti_r);
  assign top_ext   = fss_pkg::CMP_W'(top);
  assign start_now = (ti_ext >= top_ext) ? fss_pkg::TI_W'(ti_ext - top_ext)
                                         : '0;
  assign found_cur = found_r || hit;
  assign start_cur = hit ? start_now : start_r;

  always_comb begin
    if (len_r == '0) begin
      pos_nxt = '0;
    end else if (found_cur) begin
      pos_nxt = fss_pkg::POS_W'(start_cur);
    end else begin
      pos_nxt = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_case_r <= 1'b1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      fold_case_r <= cfg_if.fold_case;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      ti_r    <= '0;
      found_r <= 1'b0;
      start_r <= '0;
    end else if (emit) begin
      len_r   <= '0;
      ti_r    <= '0;
      found_r <= 1'b0;
      start_r <= '0;
    end else begin
      if (pat_load) begin
        len_r <= len_r + fss_pkg::LEN_W'(1);
      end
      if (step && (ti_r < fss_pkg::TI_W'(fss_pkg::TEXT_MAX - 1))) begin
        ti_r <= ti_r + fss_pkg::TI_W'(1);
      end
      found_r <= found_cur;
      start_r <= start_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pos_r   <= pos_nxt;
      out_found_r <= (len_r == '0) || found_cur;
    end
  end

endmodule
